/* rtl/core/fifo_evicting_key_table_assert.svh */
// Assertion macros used by the key table top level.
`ifndef FIFO_EVICTING_KEY_TABLE_ASSERT_SVH
`define FIFO_EVICTING_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FETK_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FETK_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fetk_pkg.sv */
// Shared constants, codes and types of the key table.
package fetk_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 64;
  localparam int COUNT_BITS = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ENTRY_W    = 7;
  localparam int REFS_W     = 32;

  // Operation codes carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FORGET = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic             lookup;
    logic             remove;
    logic             append;
    logic [IDX_W-1:0] append_pos;
  } cell_ctl_t;

endpackage

/* rtl/core/fetk_cell.sv */
// One slot of the ordered table: holds a key and count, compares and shifts.
module fetk_cell (
  input  logic                            clk,
  input  logic [fetk_pkg::IDX_W-1:0]      idx,
  input  logic [fetk_pkg::CNT_W-1:0]      live,
  input  fetk_pkg::cell_ctl_t             ctl,
  input  logic [fetk_pkg::KEY_BITS-1:0]   cmp_key,
  input  logic [fetk_pkg::KEY_BITS-1:0]   wr_key,
  input  logic [fetk_pkg::COUNT_BITS-1:0] wr_count,
  input  logic [fetk_pkg::KEY_BITS-1:0]   nbr_key,
  input  logic [fetk_pkg::COUNT_BITS-1:0] nbr_count,
  input  logic                            prefix_in,
  output logic                            prefix_out,
  output logic                            hit,
  output logic [fetk_pkg::KEY_BITS-1:0]   key,
  output logic [fetk_pkg::COUNT_BITS-1:0] count,
  output logic [fetk_pkg::COUNT_BITS-1:0] hit_count
);

  logic occupied;
  logic shift;

  // A slot is live when its position lies below the live entry count.
  assign occupied = ({1'b0, idx} < live);

  // From the removal point on, every slot takes its right neighbor.
  assign prefix_out = prefix_in | hit;
  assign shift      = ctl.remove & prefix_out;
  assign hit_count  = hit ? count : '0;

  // Match flag is captured when the request is taken.
  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      hit <= occupied && (key == cmp_key);
    end
  end

  // Append wins over the shift at the newest position.
  always_ff @(posedge clk) begin
    if (ctl.append && (idx == ctl.append_pos)) begin
      key   <= wr_key;
      count <= wr_count;
    end else if (shift) begin
      key   <= nbr_key;
      count <= nbr_count;
    end
  end

endmodule

/* rtl/core/fifo_evicting_key_table.sv */
// Top level of the insertion-ordered key table with oldest-first eviction.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: operation; tdata: key, residual_refs
//  m_*       out  m_tvalid/m_tready  tuser: known; tdata: stored_refs, entry_count
//
// Each request is taken in the idle state, where the cells compare their keys
// on the accept edge; the update state then shifts the chain and appends
// the new entry. A result sits in the output register while the next request
// is taken; the update state waits only while that register is still full.
// Reset clears the live entry count; slot contents need no clearing.
module fifo_evicting_key_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,   // [1:0] operation
  input  logic [95:0]  s_tdata,   // [63:0] key, [95:64] residual_refs
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [0:0]   m_tuser,   // [0] known
  output logic [39:0]  m_tdata    // [31:0] stored_refs, [38:32] entry_count, [39] zero
);

  `include "fifo_evicting_key_table_assert.svh"

  localparam int CAP   = fetk_pkg::CAPACITY;
  localparam int KW    = fetk_pkg::KEY_BITS;
  localparam int CW    = fetk_pkg::COUNT_BITS;
  localparam int IDX_W = fetk_pkg::IDX_W;
  localparam int CNT_W = fetk_pkg::CNT_W;

  fetk_pkg::state_t    state;
  fetk_pkg::state_t    state_next;
  fetk_pkg::cell_ctl_t ctl;

  logic [1:0]       req_op;
  logic [KW-1:0]    req_key;
  logic [CW-1:0]    req_refs;
  logic [CNT_W-1:0] live;
  logic [CNT_W-1:0] live_rm;
  logic [CNT_W-1:0] live_next;

  logic [KW-1:0] cell_key   [CAP+1];
  logic [CW-1:0] cell_count [CAP+1];
  logic [CW-1:0] hit_cnt    [CAP];
  logic [CAP:0]  prefix;
  logic [CAP-1:0] hit_vec;

  logic accept;
  logic out_free;
  logic commit;
  logic key_nz;
  logic is_ins;
  logic is_fgt;
  logic is_qry;
  logic any_hit;
  logic remove_hit;
  logic evict;
  logic [CW-1:0] found_count;

  // Handshake and sequencing.
  assign s_tready = (state == fetk_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == fetk_pkg::ST_APPLY) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      fetk_pkg::ST_IDLE: begin
        if (accept) state_next = fetk_pkg::ST_APPLY;
      end
      fetk_pkg::ST_APPLY: begin
        if (out_free) state_next = fetk_pkg::ST_IDLE;
      end
      default: state_next = fetk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fetk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= s_tuser;
      req_key  <= s_tdata[KW-1:0];
      req_refs <= s_tdata[KW +: CW];
    end
  end

  // Decode of the held request.
  assign key_nz = (req_key != '0);
  assign is_ins = key_nz && (req_op == fetk_pkg::OP_INSERT);
  assign is_fgt = key_nz && (req_op == fetk_pkg::OP_FORGET);
  assign is_qry = key_nz && (req_op == fetk_pkg::OP_QUERY);

  assign any_hit    = |hit_vec;
  assign remove_hit = (is_ins || is_fgt) && any_hit;
  assign evict      = is_ins && !any_hit && (live == CNT_W'(CAP));
  assign live_rm    = live - CNT_W'(remove_hit || evict);
  assign live_next  = live_rm + CNT_W'(is_ins);

  // Broadcast control to the cells.
  always_comb begin
    ctl.lookup     = accept;
    ctl.remove     = commit && (remove_hit || evict);
    ctl.append     = commit && is_ins;
    ctl.append_pos = live_rm[IDX_W-1:0];
  end

  // Eviction of the oldest entry starts the shift at the first cell.
  assign prefix[0]       = evict;
  assign cell_key[CAP]   = '0;
  assign cell_count[CAP] = '0;

  // The chain of slots, oldest at position zero.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    fetk_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .live       (live),
      .ctl        (ctl),
      .cmp_key    (s_tdata[KW-1:0]),
      .wr_key     (req_key),
      .wr_count   (req_refs),
      .nbr_key    (cell_key[i+1]),
      .nbr_count  (cell_count[i+1]),
      .prefix_in  (prefix[i]),
      .prefix_out (prefix[i+1]),
      .hit        (hit_vec[i]),
      .key        (cell_key[i]),
      .count      (cell_count[i]),
      .hit_count  (hit_cnt[i])
    );
  end

  // At most one live slot matches, so an OR picks its count.
  always_comb begin
    found_count = '0;
    for (int i = 0; i < CAP; i++) begin
      found_count = found_count | hit_cnt[i];
    end
  end

  // Live entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (commit) begin
      live <= live_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser[0]     <= is_qry && any_hit;
      m_tdata[31:0]  <= (is_qry && any_hit) ? 32'(found_count) : '0;
      m_tdata[38:32] <= 7'(live_next);
      m_tdata[39]    <= 1'b0;
    end
  end

  // Checks on the table's own bookkeeping.
  `FETK_ASSERT_NOW(a_hit_unique, state == fetk_pkg::ST_APPLY, $onehot0(hit_vec), "duplicate key")
  `FETK_ASSERT_NOW(a_live_bound, 1'b1, live <= CNT_W'(CAP), "live count above capacity")
  `FETK_ASSERT_NEXT(a_accept_apply, accept, state == fetk_pkg::ST_APPLY, "no update cycle")
  `FETK_ASSERT_NEXT(a_insert_nonempty, commit && is_ins, live != '0, "insert left table empty")

endmodule

/* tb/sv/fifo_evicting_key_table_checker.sv */
// Checker that predicts and compares every lookup table reply.
`timescale 1ns / 1ps

module key_table_checker
  import fetk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] operation
  input  logic [95:0] s_tdata,   // [63:0] key, [95:64] residual_refs
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [0:0]  m_tuser,   // [0] known
  input  logic [39:0] m_tdata,   // [31:0] stored_refs, [38:32] entry_count, [39] zero
  output int          mismatches,
  output int          outstanding
);

  // One reply as the block should present it.
  typedef struct packed {
    logic              known;
    logic [REFS_W-1:0]  refs;
    logic [ENTRY_W-1:0] count;
  } table_reply_t;

  // Shadow copy of the table, oldest entry first.
  logic [KEY_BITS-1:0]   shadow_keys [CAPACITY];
  logic [COUNT_BITS-1:0] shadow_refs [CAPACITY];
  int                    shadow_fill;

  table_reply_t replies_due[$];
  int           error_total;

  // Remove the entry at pos and close the gap behind it.
  function automatic void shadow_drop(int pos);
    for (int i = pos; i + 1 < shadow_fill; i++) begin
      shadow_keys[i] = shadow_keys[i + 1];
      shadow_refs[i] = shadow_refs[i + 1];
    end
    shadow_fill--;
  endfunction

  // Apply one request to the shadow table and return the reply it causes.
  function automatic table_reply_t shadow_apply(logic [1:0] op, logic [KEY_BITS-1:0] key,
                                                logic [COUNT_BITS-1:0] refs);
    table_reply_t r;
    int           hit;
    r   = '0;
    hit = -1;
    if (key != '0) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (hit < 0 && shadow_keys[i] == key) hit = i;
      end
      case (op)
        OP_INSERT: begin
          // A refresh drops the old copy; a new key into a full table evicts the oldest.
          if (hit >= 0) shadow_drop(hit);
          if (shadow_fill >= CAPACITY) shadow_drop(0);
          shadow_keys[shadow_fill] = key;
          shadow_refs[shadow_fill] = refs;
          shadow_fill++;
        end
        OP_FORGET: begin
          if (hit >= 0) shadow_drop(hit);
        end
        OP_QUERY: begin
          if (hit >= 0) begin
            r.known = 1'b1;
            r.refs  = shadow_refs[hit];
          end
        end
        default: begin
        end
      endcase
    end
    r.count = ENTRY_W'(shadow_fill);
    return r;
  endfunction

  // Results are checked before the request of the same edge is predicted,
  // since a reply can never leave on the edge its request was taken.
  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t got;
    if (rst) begin
      replies_due.delete();
      shadow_fill = 0;
      error_total = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.known = m_tuser[0];
        got.refs  = m_tdata[31:0];
        got.count = m_tdata[38:32];
        if (replies_due.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("[%0t] reply with no request pending: known=%0d refs=%h count=%0d",
                     $realtime, got.known, got.refs, got.count);
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          if (got.known !== want.known || got.refs !== want.refs ||
              got.count !== want.count || m_tdata[39] !== 1'b0) begin
            error_total++;
            if (error_total <= 10)
              $display("[%0t] reply mismatch: known %0d/%0d refs %h/%h count %0d/%0d pad %b",
                       $realtime, want.known, got.known, want.refs, got.refs,
                       want.count, got.count, m_tdata[39]);
          end
        end
      end
      if (s_tvalid && s_tready)
        replies_due.insert(replies_due.size(),
                           shadow_apply(s_tuser, s_tdata[63:0], s_tdata[95:64]));
    end
    mismatches  <= error_total;
    outstanding <= replies_due.size();
  end

endmodule

/* tb/sv/tb_fifo_evicting_key_table.sv */
// Top of the key table testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_fifo_evicting_key_table;
  import fetk_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         POOL_SIZE   = 96;
  localparam int         TARGET      = 1100;
  localparam int         STALL_LIMIT = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [1:0]  s_tuser;    // [1:0] operation
  logic [95:0] s_tdata;    // [63:0] key, [95:64] residual_refs
  logic        m_tvalid;
  logic        m_tready;
  logic [0:0]  m_tuser;    // [0] known
  logic [39:0] m_tdata;    // [31:0] stored_refs, [38:32] entry_count, [39] zero

  int          mismatches;
  int          outstanding;
  logic [63:0] key_pool [POOL_SIZE];
  logic        quiet;
  int          rx_stall;
  int          idle_cycles;

  fifo_evicting_key_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  key_table_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tuser     (m_tuser),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Reply side: stalls in bursts of random length unless the run is quiet.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (quiet) begin
      m_tready <= 1'b1;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      rx_stall <= $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request and hold it until it is taken.
  task automatic send_request(input logic [1:0] op, input logic [63:0] key,
                              input logic [31:0] refs);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {refs, key};
    do @(posedge clk); while (!s_tready);
  endtask

  // Random gap on the request side, skipped while the run is quiet.
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return {$urandom, $urandom};
    if (r < 30) return key_pool[$urandom_range(0, 7)];
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [31:0] pick_refs();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Operation mix per phase: insert, forget and query shares in percent.
  function automatic logic [1:0] pick_op(int phase);
    int r;
    int w_ins;
    int w_fgt;
    int w_qry;
    r = $urandom_range(0, 99);
    if (phase == 0) begin
      w_ins = 80; w_fgt = 5;  w_qry = 13;
    end else begin
      case (phase % 4)
        0: begin w_ins = 40; w_fgt = 20; w_qry = 35; end
        1: begin w_ins = 20; w_fgt = 45; w_qry = 30; end
        2: begin w_ins = 70; w_fgt = 5;  w_qry = 23; end
        default: begin w_ins = 30; w_fgt = 10; w_qry = 57; end
      endcase
    end
    if (r < w_ins) return OP_INSERT;
    if (r < w_ins + w_fgt) return OP_FORGET;
    if (r < w_ins + w_fgt + w_qry) return OP_QUERY;
    return OP_UNUSED;
  endfunction

  initial begin
    int          sent;
    int          phase;
    logic [1:0]  op;
    logic [63:0] key;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= '0;
    s_tdata  <= '0;
    quiet    <= 1'b0;

    // Key pool: a few extreme handles, the rest random and non-zero.
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0) key_pool[i] = 64'(i + 1);
    end
    key_pool[0] = '1;
    key_pool[1] = 64'd1;
    key_pool[2] = 64'h8000_0000_0000_0000;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, extremes, refresh, forget, zero key, unused code.
    send_request(OP_QUERY,  key_pool[0], 32'h0);            maybe_gap();
    send_request(OP_FORGET, key_pool[0], 32'h0);            maybe_gap();
    send_request(OP_INSERT, key_pool[0], 32'hFFFF_FFFF);    maybe_gap();
    send_request(OP_INSERT, key_pool[1], 32'h0);            maybe_gap();
    send_request(OP_INSERT, key_pool[2], 32'h8000_0001);    maybe_gap();
    send_request(OP_QUERY,  key_pool[0], 32'h0);            maybe_gap();
    send_request(OP_QUERY,  key_pool[1], 32'hFFFF_FFFF);    maybe_gap();
    send_request(OP_QUERY,  key_pool[2], 32'h0);            maybe_gap();
    send_request(OP_INSERT, key_pool[0], 32'h1234_5678);    maybe_gap();
    send_request(OP_QUERY,  key_pool[0], 32'h0);            maybe_gap();
    send_request(OP_FORGET, key_pool[1], 32'h0);            maybe_gap();
    send_request(OP_QUERY,  key_pool[1], 32'h0);            maybe_gap();
    send_request(OP_FORGET, key_pool[1], 32'h0);            maybe_gap();
    send_request(OP_INSERT, 64'h0,       32'hFFFF_FFFF);    maybe_gap();
    send_request(OP_QUERY,  64'h0,       32'h0);            maybe_gap();
    send_request(OP_FORGET, 64'h0,       32'h0);            maybe_gap();
    send_request(OP_UNUSED, key_pool[2], 32'hFFFF_FFFF);    maybe_gap();
    send_request(OP_QUERY,  key_pool[2], 32'h0);            maybe_gap();
    send_request(OP_QUERY,  {$urandom, $urandom}, 32'h0);   maybe_gap();
    send_request(OP_INSERT, key_pool[3], 32'h0);            maybe_gap();
    send_request(OP_FORGET, key_pool[0], 32'h0);            maybe_gap();
    send_request(OP_FORGET, key_pool[2], 32'h0);            maybe_gap();
    send_request(OP_FORGET, key_pool[3], 32'h0);            maybe_gap();
    send_request(OP_QUERY,  key_pool[3], 32'h0);            maybe_gap();

    // Random part in phases of changing mix; some phases and the tail run without idling.
    sent = 0;
    while (sent < TARGET) begin
      phase = sent / 100;
      quiet <= (phase == 3 || phase == 7 || phase >= 10);
      op  = pick_op(phase);
      key = pick_key();
      send_request(op, key, pick_refs());
      sent++;
      maybe_gap();
    end
    s_tvalid <= 1'b0;

    // Drain, then let the block settle before the verdict.
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
